FILE: hw/rtl/sktbl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sktbl_pkg;

  // request codes
  typedef enum logic [2:0] {
    OP_INSERT   = 3'd0,
    OP_DEL_KEY  = 3'd1,
    OP_DEL_IDX  = 3'd2,
    OP_POP      = 3'd3,
    OP_LOOKUP   = 3'd4,
    OP_READ_IDX = 3'd5,
    OP_NEXT_FREE = 3'd6,
    OP_COUNT    = 3'd7
  } op_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  localparam int KEY_W  = 32;
  localparam int DATA_W = 32;
  localparam int IDX_W  = 6;
  localparam int POS_W  = 7;
  localparam logic [KEY_W-1:0] KEY_MAX = '1;

endpackage
`default_nettype wire

FILE: hw/rtl/sorted_key_table_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Sorted key/data table, up to CAPACITY pairs kept in ascending key order.
// Request channel: op, key, data and index are taken at a rising edge with
// start high and busy low. busy stays high until the request is finished.
// Result channel: done is high for exactly one cycle with status, position,
// key_out, data_out and count_out; the receiver cannot hold a result off.
// Entries live in one single-port-write, registered-read memory of
// {key, data} words. A key search probes one entry at a time, an address
// state then a compare state. Insert and delete move one entry at a time,
// a read state then a write state for each, after any search. Read by
// index passes through a fetch state; count and refused requests are
// answered from idle. Next-free-key repeats the search once for each taken
// key it steps over.
// A new request can be taken in the cycle that shows done.
// Reset empties the table at once (the count returns to zero); memory
// contents are not cleared and are never read before being written.
module sorted_key_table_core #(
  parameter int CAPACITY = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire sktbl_pkg::op_t                op,
  input  wire logic [sktbl_pkg::KEY_W-1:0]   key,
  input  wire logic [sktbl_pkg::DATA_W-1:0]  data,
  input  wire logic [sktbl_pkg::IDX_W-1:0]   index,
  output logic                               done,
  output sktbl_pkg::status_t                 status,
  output logic [sktbl_pkg::POS_W-1:0]        position,
  output logic [sktbl_pkg::KEY_W-1:0]        key_out,
  output logic [sktbl_pkg::DATA_W-1:0]       data_out,
  output logic [sktbl_pkg::POS_W-1:0]        count_out
);
  import sktbl_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int WW = KEY_W + DATA_W;

  typedef enum logic [3:0] {
    S_IDLE, S_PROBE, S_CMP, S_INS_RD, S_INS_WR, S_INS_PUT,
    S_DEL_RD, S_DEL_WR, S_IDX_GET
  } state_t;

  state_t state;
  op_t op_q;
  logic [KEY_W-1:0]  key_q;
  logic [DATA_W-1:0] data_q;
  logic [CW-1:0] count;
  logic [CW-1:0] ptr;
  logic [CW-1:0] pos_r;
  logic signed [CW:0] lo, hi;
  logic [AW-1:0] mid;

  // table memory
  logic [WW-1:0] mem [CAPACITY];
  logic [WW-1:0] rd_q;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          wr_en;
  logic [WW-1:0] wr_word;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_word;
    end
    rd_q <= mem[rd_addr];
  end

  // search arithmetic
  logic signed [CW+1:0] lh_sum;
  logic [AW-1:0] mid_calc;
  logic signed [CW:0] mid_s;
  logic [CW-1:0] mid_cw;
  logic [KEY_W-1:0] probe_key;
  logic key_eq, key_lt;
  logic signed [CW:0] lo_new, hi_new;
  logic [CW-1:0] hit_pos;
  logic [31:0] idx_w, cnt_w, pos_w, cnt_ow;
  logic [CW-1:0] idx_cw;
  logic [CW-1:0] ptr_m1;
  logic [CW-1:0] ptr_p1;
  logic [CW-1:0] count_m1;

  assign lh_sum    = (CW+2)'(lo) + (CW+2)'(hi);
  assign mid_calc  = lh_sum[AW:1];
  assign mid_s     = $signed({{(CW+1-AW){1'b0}}, mid});
  assign mid_cw    = mid_s[CW-1:0];
  assign probe_key = rd_q[WW-1:DATA_W];
  assign key_eq    = (key_q == probe_key);
  assign key_lt    = (key_q < probe_key);
  assign lo_new    = key_lt ? lo : mid_s + (CW+1)'(1);
  assign hi_new    = key_lt ? mid_s - (CW+1)'(1) : hi;
  assign hit_pos   = (key_eq || key_lt) ? mid_cw : mid_cw + CW'(1);
  assign idx_w     = 32'(index);
  assign cnt_w     = 32'(count);
  assign idx_cw    = idx_w[CW-1:0];
  assign ptr_m1    = ptr - CW'(1);
  assign ptr_p1    = ptr + CW'(1);
  assign count_m1  = count - CW'(1);

  // memory port addressing per state
  always_comb begin
    rd_addr = mid_calc;
    wr_addr = ptr[AW-1:0];
    wr_en   = 1'b0;
    wr_word = rd_q;
    case (state)
      S_PROBE:   rd_addr = mid_calc;
      S_INS_RD:  rd_addr = ptr_m1[AW-1:0];
      S_INS_WR:  wr_en = 1'b1;
      S_INS_PUT: begin
        wr_en   = 1'b1;
        wr_addr = pos_r[AW-1:0];
        wr_word = {key_q, data_q};
      end
      S_DEL_RD:  rd_addr = ptr_p1[AW-1:0];
      S_DEL_WR:  wr_en = 1'b1;
      S_IDLE: begin
        if (op == OP_POP) begin
          rd_addr = count_m1[AW-1:0];
        end else begin
          rd_addr = idx_cw[AW-1:0];
        end
      end
      default: ;
    endcase
  end

  // control sequencer and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
      ptr   <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          ptr <= count;
          if (start) begin
            op_q     <= op;
            key_q    <= key;
            data_q   <= data;
            status   <= ST_OK;
            pos_r    <= '0;
            key_out  <= '0;
            data_out <= '0;
            lo       <= '0;
            hi       <= $signed({1'b0, count}) - (CW+1)'(1);
            case (op)
              OP_INSERT: begin
                if (cnt_w >= 32'(CAPACITY)) begin
                  status <= ST_FULL;
                  done   <= 1'b1;
                end else if (count == '0) begin
                  state <= S_INS_PUT;
                end else begin
                  state <= S_PROBE;
                end
              end
              OP_DEL_KEY, OP_LOOKUP: begin
                if (count == '0) begin
                  status <= ST_MISS;
                  done   <= 1'b1;
                end else begin
                  state <= S_PROBE;
                end
              end
              OP_NEXT_FREE: begin
                if (count == '0) begin
                  key_out <= key;
                  done    <= 1'b1;
                end else begin
                  state <= S_PROBE;
                end
              end
              OP_POP: begin
                if (count == '0) begin
                  status <= ST_MISS;
                  done   <= 1'b1;
                end else begin
                  pos_r <= count_m1;
                  state <= S_IDX_GET;
                end
              end
              OP_DEL_IDX, OP_READ_IDX: begin
                if (idx_w >= cnt_w) begin
                  status <= ST_MISS;
                  done   <= 1'b1;
                end else begin
                  pos_r <= idx_cw;
                  state <= S_IDX_GET;
                end
              end
              default: done <= 1'b1;
            endcase
          end
        end
        S_PROBE: begin
          mid   <= mid_calc;
          state <= S_CMP;
        end
        S_CMP: begin
          lo <= lo_new;
          hi <= hi_new;
          if (!key_eq && lo_new <= hi_new) begin
            state <= S_PROBE;
          end else begin
            pos_r <= hit_pos;
            case (op_q)
              OP_INSERT: begin
                ptr <= count;
                if (count > hit_pos) state <= S_INS_RD;
                else state <= S_INS_PUT;
              end
              OP_NEXT_FREE: begin
                if (key_eq && key_q != KEY_MAX) begin
                  key_q <= key_q + KEY_W'(1);
                  lo    <= '0;
                  hi    <= $signed({1'b0, count}) - (CW+1)'(1);
                  state <= S_PROBE;
                end else begin
                  if (key_eq) status <= ST_MISS;
                  key_out <= key_q;
                  state   <= S_IDLE;
                  done    <= 1'b1;
                end
              end
              default: begin
                if (!key_eq) begin
                  status <= ST_MISS;
                  state  <= S_IDLE;
                  done   <= 1'b1;
                end else begin
                  key_out  <= probe_key;
                  data_out <= rd_q[DATA_W-1:0];
                  if (op_q == OP_DEL_KEY) begin
                    ptr   <= hit_pos;
                    state <= S_DEL_RD;
                  end else begin
                    state <= S_IDLE;
                    done  <= 1'b1;
                  end
                end
              end
            endcase
          end
        end
        S_INS_RD: state <= S_INS_WR;
        S_INS_WR: begin
          ptr <= ptr_m1;
          if (ptr_m1 > pos_r) state <= S_INS_RD;
          else state <= S_INS_PUT;
        end
        S_INS_PUT: begin
          count <= count + CW'(1);
          state <= S_IDLE;
          done  <= 1'b1;
        end
        S_IDX_GET: begin
          key_out  <= probe_key;
          data_out <= rd_q[DATA_W-1:0];
          ptr      <= pos_r;
          if (op_q == OP_READ_IDX) begin
            state <= S_IDLE;
            done  <= 1'b1;
          end else begin
            state <= S_DEL_RD;
          end
        end
        S_DEL_RD: begin
          if (ptr_p1 < count) begin
            state <= S_DEL_WR;
          end else begin
            count <= count - CW'(1);
            state <= S_IDLE;
            done  <= 1'b1;
          end
        end
        S_DEL_WR: begin
          ptr   <= ptr_p1;
          state <= S_DEL_RD;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign busy      = (state != S_IDLE);
  assign pos_w     = 32'(pos_r);
  assign position  = pos_w[POS_W-1:0];
  assign cnt_ow    = 32'(count);
  assign count_out = cnt_ow[POS_W-1:0];

  // checks
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy || done)
    else $error("accepted request left no trace");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while still working");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    cnt_w <= 32'(CAPACITY))
    else $error("entry count beyond capacity");
  a_full_only_full: assert property (@(posedge clk) disable iff (rst)
    done && status == ST_FULL |-> cnt_w == 32'(CAPACITY))
    else $error("full reported on a table with room");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !done && !$past(rst) |-> $stable(count))
    else $error("count changed without a result");

endmodule
`default_nettype wire
